@@ hw/rtl/pfa_pkg.sv @@
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int MAX_PARTS = 32;
    localparam int AW        = 16;
    localparam int IDX_W     = $clog2(MAX_PARTS);
    localparam int CNT_W     = $clog2(MAX_PARTS + 1);

    localparam logic [AW-1:0] RESET_MEM_SIZE   = AW'(4096);
    localparam logic [15:0]   RESET_FRAG_LIMIT = 16'd5;

    localparam logic       MODE_ALLOC = 1'b0;
    localparam logic       MODE_FREE  = 1'b1;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_BADREL = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_MARK,
        OP_FREE,
        OP_SPLIT,
        OP_MERGE
    } t_tbl_op;

    typedef struct packed {
        t_tbl_op          op;
        logic [IDX_W-1:0] idx;
        logic [AW-1:0]    size;
        logic [AW-1:0]    start2;
        logic [AW-1:0]    size2;
    } t_tbl_cmd;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] idx;
        logic [AW-1:0]    start;
        logic [AW-1:0]    size;
        logic [CNT_W-1:0] probes;
        logic [CNT_W-1:0] frags;
    } t_result;

endpackage

@@ hw/rtl/pfa_table.sv @@
`timescale 1ns / 1ps

module pfa_table import pfa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rebuild,
    input  logic [AW-1:0]    i_mem_size,
    input  t_tbl_cmd         i_cmd,
    input  logic [IDX_W-1:0] i_ptr,
    output logic [AW-1:0]    o_rd_start,
    output logic [AW-1:0]    o_rd_size,
    output logic             o_rd_used,
    output logic [CNT_W-1:0] o_count
);

    logic [AW-1:0]    r_start [MAX_PARTS];
    logic [AW-1:0]    r_size  [MAX_PARTS];
    logic             r_used  [MAX_PARTS];
    logic [CNT_W-1:0] r_count;

    logic [AW-1:0]    n_start [MAX_PARTS];
    logic [AW-1:0]    n_size  [MAX_PARTS];
    logic             n_used  [MAX_PARTS];
    logic [CNT_W-1:0] n_count;

    logic [IDX_W-1:0] w_nxt;

    assign w_nxt      = i_cmd.idx + IDX_W'(1);
    assign o_rd_start = r_start[i_ptr];
    assign o_rd_size  = r_size[i_ptr];
    assign o_rd_used  = r_used[i_ptr];
    assign o_count    = r_count;

    always_comb begin
        n_start = r_start;
        n_size  = r_size;
        n_used  = r_used;
        n_count = r_count;
        if (i_rebuild) begin
            n_start[0] = '0;
            n_size[0]  = i_mem_size;
            n_used[0]  = 1'b0;
            n_count    = CNT_W'(1);
        end else begin
            unique case (i_cmd.op)
                OP_NOP: begin
                end
                OP_MARK: begin
                    n_used[i_cmd.idx] = 1'b1;
                end
                OP_FREE: begin
                    n_used[i_cmd.idx] = 1'b0;
                end
                OP_SPLIT: begin
                    for (int j = 1; j < MAX_PARTS; j++) begin
                        if (IDX_W'(j) > w_nxt) begin
                            n_start[j] = r_start[j-1];
                            n_size[j]  = r_size[j-1];
                            n_used[j]  = r_used[j-1];
                        end
                    end
                    n_used[i_cmd.idx] = 1'b1;
                    n_size[i_cmd.idx] = i_cmd.size;
                    n_start[w_nxt]    = i_cmd.start2;
                    n_size[w_nxt]     = i_cmd.size2;
                    n_used[w_nxt]     = 1'b0;
                    n_count           = r_count + CNT_W'(1);
                end
                OP_MERGE: begin
                    for (int j = 0; j < MAX_PARTS - 1; j++) begin
                        if (IDX_W'(j) > i_cmd.idx) begin
                            n_start[j] = r_start[j+1];
                            n_size[j]  = r_size[j+1];
                            n_used[j]  = r_used[j+1];
                        end
                    end
                    n_size[i_cmd.idx] = i_cmd.size;
                    n_used[i_cmd.idx] = 1'b0;
                    n_count           = r_count - CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_PARTS; j++) begin
                r_start[j] <= '0;
                r_size[j]  <= '0;
                r_used[j]  <= 1'b0;
            end
            r_size[0] <= RESET_MEM_SIZE;
            r_count   <= CNT_W'(1);
        end else begin
            r_start <= n_start;
            r_size  <= n_size;
            r_used  <= n_used;
            r_count <= n_count;
        end
    end

endmodule

@@ hw/rtl/pfa_seq.sv @@
`timescale 1ns / 1ps

module pfa_seq import pfa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_mode,
    input  logic [1:0]       i_fit_policy,
    input  logic [AW-1:0]    i_request_size,
    input  logic [IDX_W-1:0] i_release_index,
    input  logic [15:0]      i_frag_limit,
    input  logic [AW-1:0]    i_rd_start,
    input  logic [AW-1:0]    i_rd_size,
    input  logic             i_rd_used,
    input  logic [CNT_W-1:0] i_count,
    output logic [IDX_W-1:0] o_ptr,
    output t_tbl_cmd         o_cmd,
    output logic             o_done,
    input  logic             i_take,
    output t_result          o_res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FF    = 4'd1;
    localparam logic [3:0] S_BW1   = 4'd2;
    localparam logic [3:0] S_BW2   = 4'd3;
    localparam logic [3:0] S_ALLOC = 4'd4;
    localparam logic [3:0] S_REL0  = 4'd5;
    localparam logic [3:0] S_REL1  = 4'd6;
    localparam logic [3:0] S_REL2  = 4'd7;
    localparam logic [3:0] S_REL3  = 4'd8;
    localparam logic [3:0] S_FRAG  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]       r_state, n_state;
    logic [IDX_W-1:0] r_ptr, n_ptr;
    logic [1:0]       r_policy, n_policy;
    logic [AW-1:0]    r_n, n_n;
    logic [IDX_W-1:0] r_rel, n_rel;
    logic [IDX_W-1:0] r_pick, n_pick;
    logic [AW-1:0]    r_pick_size, n_pick_size;
    logic             r_found, n_found;
    logic [AW-1:0]    r_cur, n_cur;
    t_result          r_res, n_res;

    logic             w_last;
    logic             w_best;
    logic             w_better;
    logic             w_order;
    logic             w_has_next;
    logic [AW-1:0]    w_sum;

    assign w_last     = (CNT_W'(r_ptr) + CNT_W'(1)) == i_count;
    assign w_best     = r_policy == POL_BEST;
    assign w_order    = w_best ? (i_rd_size < r_pick_size) : (i_rd_size > r_pick_size);
    assign w_better   = !i_rd_used && (i_rd_size >= r_n) && (!r_found || w_order);
    assign w_has_next = (CNT_W'(r_rel) + CNT_W'(1)) < i_count;
    assign w_sum      = r_cur + i_rd_size;

    assign o_ready = r_state == S_IDLE;
    assign o_done  = r_state == S_DONE;
    assign o_ptr   = r_ptr;
    assign o_res   = r_res;

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_policy    = r_policy;
        n_n         = r_n;
        n_rel       = r_rel;
        n_pick      = r_pick;
        n_pick_size = r_pick_size;
        n_found     = r_found;
        n_cur       = r_cur;
        n_res       = r_res;
        o_cmd       = '0;
        o_cmd.op    = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_res    = '0;
                    n_found  = 1'b0;
                    n_ptr    = '0;
                    n_n      = i_request_size;
                    n_rel    = i_release_index;
                    n_policy = (i_fit_policy == POL_BEST || i_fit_policy == POL_WORST) ?
                               i_fit_policy : POL_FIRST;
                    if (i_mode == MODE_ALLOC) begin
                        if (i_request_size == '0) begin
                            n_res.status = ST_NOFIT;
                            n_state      = S_FRAG;
                        end else if (i_fit_policy == POL_BEST || i_fit_policy == POL_WORST) begin
                            n_state = S_BW1;
                        end else begin
                            n_state = S_FF;
                        end
                    end else if (CNT_W'(i_release_index) >= i_count) begin
                        n_res.status = ST_BADREL;
                        n_state      = S_FRAG;
                    end else begin
                        n_ptr   = i_release_index;
                        n_state = S_REL0;
                    end
                end
            end
            S_FF: begin
                if (!i_rd_used) begin
                    n_res.probes = r_res.probes + CNT_W'(1);
                end
                if (!i_rd_used && i_rd_size >= r_n) begin
                    n_state = S_ALLOC;
                end else if (w_last) begin
                    n_res.status = ST_NOFIT;
                    n_ptr        = '0;
                    n_state      = S_FRAG;
                end else begin
                    n_ptr = r_ptr + IDX_W'(1);
                end
            end
            S_BW1: begin
                if (w_better) begin
                    n_pick      = r_ptr;
                    n_pick_size = i_rd_size;
                    n_found     = 1'b1;
                end
                if (w_last) begin
                    n_ptr = '0;
                    if (r_found || w_better) begin
                        n_res.probes = CNT_W'(1);
                        n_state      = S_BW2;
                    end else begin
                        n_res.status = ST_NOFIT;
                        n_state      = S_FRAG;
                    end
                end else begin
                    n_ptr = r_ptr + IDX_W'(1);
                end
            end
            S_BW2: begin
                if (!i_rd_used && w_order) begin
                    n_res.probes = r_res.probes + CNT_W'(1);
                end
                if (w_last) begin
                    n_ptr   = r_pick;
                    n_state = S_ALLOC;
                end else begin
                    n_ptr = r_ptr + IDX_W'(1);
                end
            end
            S_ALLOC: begin
                n_res.idx   = r_ptr;
                n_res.start = i_rd_start;
                o_cmd.idx   = r_ptr;
                if (i_rd_size > r_n && i_count < CNT_W'(MAX_PARTS)) begin
                    o_cmd.op     = OP_SPLIT;
                    o_cmd.size   = r_n;
                    o_cmd.start2 = i_rd_start + r_n;
                    o_cmd.size2  = i_rd_size - r_n;
                    n_res.size   = r_n;
                end else begin
                    o_cmd.op   = OP_MARK;
                    n_res.size = i_rd_size;
                end
                n_ptr   = '0;
                n_state = S_FRAG;
            end
            S_REL0: begin
                if (i_rd_used) begin
                    o_cmd.op  = OP_FREE;
                    o_cmd.idx = r_ptr;
                    n_cur     = i_rd_size;
                    n_ptr     = r_ptr + IDX_W'(1);
                    n_state   = S_REL1;
                end else begin
                    n_res.status = ST_BADREL;
                    n_ptr        = '0;
                    n_state      = S_FRAG;
                end
            end
            S_REL1: begin
                if (w_has_next && !i_rd_used) begin
                    o_cmd.op   = OP_MERGE;
                    o_cmd.idx  = r_rel;
                    o_cmd.size = w_sum;
                    n_cur      = w_sum;
                end
                if (r_rel != '0) begin
                    n_ptr   = r_rel - IDX_W'(1);
                    n_state = S_REL2;
                end else begin
                    n_ptr   = r_rel;
                    n_state = S_REL3;
                end
            end
            S_REL2: begin
                if (!i_rd_used) begin
                    o_cmd.op   = OP_MERGE;
                    o_cmd.idx  = r_ptr;
                    o_cmd.size = w_sum;
                end else begin
                    n_ptr = r_rel;
                end
                n_state = S_REL3;
            end
            S_REL3: begin
                n_res.idx   = r_ptr;
                n_res.start = i_rd_start;
                n_res.size  = i_rd_size;
                n_ptr       = '0;
                n_state     = S_FRAG;
            end
            S_FRAG: begin
                if (!i_rd_used && i_rd_size <= i_frag_limit) begin
                    n_res.frags = r_res.frags + CNT_W'(1);
                end
                if (w_last) begin
                    n_state = S_DONE;
                end else begin
                    n_ptr = r_ptr + IDX_W'(1);
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_policy    <= n_policy;
        r_n         <= n_n;
        r_rel       <= n_rel;
        r_pick      <= n_pick;
        r_pick_size <= n_pick_size;
        r_cur       <= n_cur;
        r_res       <= n_res;
    end

endmodule

@@ hw/rtl/partition_allocator_fit_policies.sv @@
`timescale 1ns / 1ps

// Channel     Handshake            Payload
// request     i_valid / o_ready    i_mode, i_fit_policy, i_request_size, i_release_index
// result      o_valid / i_ready    o_status, o_part_index, o_start_address, o_part_size,
//                                  o_probe_count, o_fragment_count
// config      APB write/read       i_paddr, i_pwdata, o_prdata (pready tied high)
//
// A first fit request scans the table once, best and worst fit scan it twice, and every
// transaction ends with one scan that counts fragments, one entry longer after a split. All
// scans share one read port of the partition table, one entry per cycle.
// Reset is synchronous and leaves one free partition of 4096 units.
// A finished result waits in the output register while the next transaction is taken, and a
// later result holds the sequencer until that register is free.

module partition_allocator_fit_policies import pfa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_mode,
    input  logic [1:0]       i_fit_policy,
    input  logic [15:0]      i_request_size,
    input  logic [4:0]       i_release_index,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_status,
    output logic [4:0]       o_part_index,
    output logic [15:0]      o_start_address,
    output logic [15:0]      o_part_size,
    output logic [5:0]       o_probe_count,
    output logic [5:0]       o_fragment_count,
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic [2:0]       i_paddr,
    input  logic [31:0]      i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready
);

    logic [AW-1:0]    r_mem_size;
    logic [15:0]      r_frag_limit;
    logic             r_out_valid;
    t_result          r_out;

    logic             w_wr;
    logic             w_rebuild;
    logic             w_done;
    logic             w_load;
    t_result          w_res;
    t_tbl_cmd         w_cmd;
    logic [IDX_W-1:0] w_ptr;
    logic [AW-1:0]    w_rd_start;
    logic [AW-1:0]    w_rd_size;
    logic             w_rd_used;
    logic [CNT_W-1:0] w_count;

    assign w_wr      = i_psel && i_penable && i_pwrite;
    assign w_rebuild = w_wr && !i_paddr[2];
    assign w_load    = w_done && (!r_out_valid || i_ready);
    assign o_pready  = 1'b1;
    assign o_prdata  = i_paddr[2] ? {16'd0, r_frag_limit} : {16'd0, r_mem_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_size   <= RESET_MEM_SIZE;
            r_frag_limit <= RESET_FRAG_LIMIT;
        end else if (w_wr) begin
            if (i_paddr[2]) begin
                r_frag_limit <= i_pwdata[15:0];
            end else begin
                r_mem_size <= i_pwdata[AW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out.status;
    assign o_part_index     = r_out.idx;
    assign o_start_address  = r_out.start;
    assign o_part_size      = r_out.size;
    assign o_probe_count    = r_out.probes;
    assign o_fragment_count = r_out.frags;

    pfa_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rebuild  (w_rebuild),
        .i_mem_size (i_pwdata[AW-1:0]),
        .i_cmd      (w_cmd),
        .i_ptr      (w_ptr),
        .o_rd_start (w_rd_start),
        .o_rd_size  (w_rd_size),
        .o_rd_used  (w_rd_used),
        .o_count    (w_count)
    );

    pfa_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_fit_policy    (i_fit_policy),
        .i_request_size  (i_request_size),
        .i_release_index (i_release_index),
        .i_frag_limit    (r_frag_limit),
        .i_rd_start      (w_rd_start),
        .i_rd_size       (w_rd_size),
        .i_rd_used       (w_rd_used),
        .i_count         (w_count),
        .o_ptr           (w_ptr),
        .o_cmd           (w_cmd),
        .o_done          (w_done),
        .i_take          (w_load),
        .o_res           (w_res)
    );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import pfa_pkg::*;

    localparam int         CLK_HIGH_NS     = 6;
    localparam int         CLK_LOW_NS      = 6;
    localparam int         RESET_CYCLES    = 8;
    localparam int         STALL_LIMIT     = 4000;
    localparam int         DRAIN_CYCLES    = 150;
    localparam int         ITEMS_PER_PHASE = 270;
    localparam int         BIAS_STRETCH    = 40;
    localparam int         PHASES          = 6;
    localparam logic [2:0] ADDR_MEM_SIZE   = 3'd0;
    localparam logic [2:0] ADDR_FRAG_LIMIT = 3'd4;

    typedef struct packed {
        logic        mode;
        logic [1:0]  policy;
        logic [15:0] size;
        logic [4:0]  index;
    } t_part_request;

    logic        i_clk = 1'b1;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_mode = MODE_ALLOC;
    logic [1:0]  i_fit_policy = POL_FIRST;
    logic [15:0] i_request_size = '0;
    logic [4:0]  i_release_index = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [4:0]  o_part_index;
    logic [15:0] o_start_address;
    logic [15:0] o_part_size;
    logic [5:0]  o_probe_count;
    logic [5:0]  o_fragment_count;
    logic        i_psel = 1'b0;
    logic        i_penable = 1'b0;
    logic        i_pwrite = 1'b0;
    logic [2:0]  i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic        o_pready;

    partition_allocator_fit_policies u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_fit_policy     (i_fit_policy),
        .i_request_size   (i_request_size),
        .i_release_index  (i_release_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_part_index     (o_part_index),
        .o_start_address  (o_start_address),
        .o_part_size      (o_part_size),
        .o_probe_count    (o_probe_count),
        .o_fragment_count (o_fragment_count),
        .i_psel           (i_psel),
        .i_penable        (i_penable),
        .i_pwrite         (i_pwrite),
        .i_paddr          (i_paddr),
        .i_pwdata         (i_pwdata),
        .o_prdata         (o_prdata),
        .o_pready         (o_pready)
    );

    always begin
        i_clk = 1'b1;
        #CLK_HIGH_NS;
        i_clk = 1'b0;
        #CLK_LOW_NS;
    end

    // Shadow copy of the partition table and the configuration registers.
    logic [15:0]     tbl_start [MAX_PARTS];
    logic [15:0]     tbl_size  [MAX_PARTS];
    logic            tbl_used  [MAX_PARTS];
    int              tbl_count;
    logic [15:0]     cfg_mem_size;
    logic [15:0]     cfg_frag_limit;

    t_part_request   pending_requests [$];
    t_result         predicted_outcomes [$];
    int              requests_queued = 0;
    int              requests_taken = 0;
    int              results_checked = 0;
    int              alloc_count = 0;
    int              release_count = 0;
    int              full_table_grants = 0;
    int              mismatch_count = 0;
    int              stall_cycles = 0;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              alloc_bias = 60;
    logic            req_fire = 1'b0;

    function automatic void rebuild_table();
        int i;
        for (i = 0; i < MAX_PARTS; i++) begin
            tbl_start[i] = '0;
            tbl_size[i]  = '0;
            tbl_used[i]  = 1'b0;
        end
        tbl_size[0] = cfg_mem_size;
        tbl_count   = 1;
    endfunction

    function automatic void remove_entry(int k);
        int j;
        for (j = k; j + 1 < tbl_count; j++) begin
            tbl_start[j] = tbl_start[j + 1];
            tbl_size[j]  = tbl_size[j + 1];
            tbl_used[j]  = tbl_used[j + 1];
        end
        tbl_count--;
    endfunction

    function automatic void split_entry(int i, logic [15:0] n);
        int k;
        for (k = tbl_count; k > i + 1; k--) begin
            tbl_start[k] = tbl_start[k - 1];
            tbl_size[k]  = tbl_size[k - 1];
            tbl_used[k]  = tbl_used[k - 1];
        end
        tbl_start[i + 1] = tbl_start[i] + n;
        tbl_size[i + 1]  = tbl_size[i] - n;
        tbl_used[i + 1]  = 1'b0;
        tbl_size[i]      = n;
        tbl_count++;
    endfunction

    function automatic logic [CNT_W-1:0] count_fragments();
        int i;
        int c;
        c = 0;
        for (i = 0; i < tbl_count; i++) begin
            if (!tbl_used[i] && tbl_size[i] <= cfg_frag_limit) begin
                c++;
            end
        end
        return CNT_W'(c);
    endfunction

    function automatic t_result apply_request(t_part_request r);
        t_result res;
        logic    found;
        int      pick;
        int      probes;
        int      i;
        int      k;
        res    = '0;
        found  = 1'b0;
        pick   = 0;
        probes = 0;
        if (r.mode == MODE_ALLOC) begin
            if (r.size != 0) begin
                if (r.policy == POL_BEST || r.policy == POL_WORST) begin
                    for (i = 0; i < tbl_count; i++) begin
                        if (!tbl_used[i] && tbl_size[i] >= r.size &&
                            (!found ||
                             (r.policy == POL_BEST && tbl_size[i] < tbl_size[pick]) ||
                             (r.policy == POL_WORST && tbl_size[i] > tbl_size[pick]))) begin
                            pick  = i;
                            found = 1'b1;
                        end
                    end
                    if (found) begin
                        probes = 1;
                        for (i = 0; i < tbl_count; i++) begin
                            if (!tbl_used[i] &&
                                ((r.policy == POL_BEST && tbl_size[i] < tbl_size[pick]) ||
                                 (r.policy == POL_WORST && tbl_size[i] > tbl_size[pick]))) begin
                                probes++;
                            end
                        end
                    end
                end else begin
                    for (i = 0; i < tbl_count && !found; i++) begin
                        if (!tbl_used[i]) begin
                            probes++;
                            if (tbl_size[i] >= r.size) begin
                                pick  = i;
                                found = 1'b1;
                            end
                        end
                    end
                end
            end
            if (found) begin
                tbl_used[pick] = 1'b1;
                if (tbl_size[pick] > r.size) begin
                    if (tbl_count < MAX_PARTS) begin
                        split_entry(pick, r.size);
                    end else begin
                        full_table_grants++;
                    end
                end
                res.idx   = IDX_W'(pick);
                res.start = tbl_start[pick];
                res.size  = tbl_size[pick];
            end else begin
                res.status = ST_NOFIT;
            end
        end else begin
            k = int'(r.index);
            if (k >= tbl_count || !tbl_used[k]) begin
                res.status = ST_BADREL;
            end else begin
                tbl_used[k] = 1'b0;
                if (k + 1 < tbl_count && !tbl_used[k + 1]) begin
                    tbl_size[k] = tbl_size[k] + tbl_size[k + 1];
                    remove_entry(k + 1);
                end
                if (k > 0 && !tbl_used[k - 1]) begin
                    tbl_size[k - 1] = tbl_size[k - 1] + tbl_size[k];
                    remove_entry(k);
                    k--;
                end
                res.idx   = IDX_W'(k);
                res.start = tbl_start[k];
                res.size  = tbl_size[k];
            end
        end
        res.probes = CNT_W'(probes);
        res.frags  = count_fragments();
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%s mismatch on result %0d: got %0d, expected %0d",
                 what, results_checked, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(t_result want);
        if (o_status != want.status)
            report_mismatch("status", o_status, want.status);
        if (o_part_index != want.idx)
            report_mismatch("part_index", o_part_index, want.idx);
        if (o_start_address != want.start)
            report_mismatch("start_address", o_start_address, want.start);
        if (o_part_size != want.size)
            report_mismatch("part_size", o_part_size, want.size);
        if (o_probe_count != want.probes)
            report_mismatch("probe_count", o_probe_count, want.probes);
        if (o_fragment_count != want.frags)
            report_mismatch("fragment_count", o_fragment_count, want.frags);
    endtask

    always @(negedge i_clk) begin : driver
        t_part_request nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_ready <= 1'b0;
        end else begin
            if (!i_valid || req_fire) begin
                if (pending_requests.size() > 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_requests.pop_front();
                    i_valid         <= 1'b1;
                    i_mode          <= nxt.mode;
                    i_fit_policy    <= nxt.policy;
                    i_request_size  <= nxt.size;
                    i_release_index <= nxt.index;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_part_request seen;
        req_fire <= i_valid && o_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (predicted_outcomes.size() == 0) begin
                    report_mismatch("unrequested result", 1, 0);
                end else begin
                    check_result(predicted_outcomes.pop_front());
                end
                results_checked++;
            end
            if (i_valid && o_ready) begin
                seen = '{i_mode, i_fit_policy, i_request_size, i_release_index};
                if (seen.mode == MODE_ALLOC) begin
                    alloc_count++;
                end else begin
                    release_count++;
                end
                predicted_outcomes.push_back(apply_request(seen));
                requests_taken <= requests_taken + 1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_valid && o_ready) || (o_valid && i_ready) ||
            (i_psel && i_penable && i_pwrite && o_pready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("no transaction for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_request(logic mode, logic [1:0] policy, logic [15:0] size,
                                logic [4:0] index);
        pending_requests.push_back('{mode, policy, size, index});
        requests_queued++;
    endtask

    task automatic push_random();
        t_part_request r;
        int            roll;
        int            limit;
        int            used_list [$];
        int            free_sizes [$];
        int            i;
        for (i = 0; i < tbl_count; i++) begin
            if (tbl_used[i]) begin
                used_list.push_back(i);
            end else begin
                free_sizes.push_back(tbl_size[i]);
            end
        end
        r.mode   = ($urandom_range(0, 99) < alloc_bias) ? MODE_ALLOC : MODE_FREE;
        r.policy = 2'($urandom_range(0, 3));
        r.index  = 5'($urandom_range(0, 31));
        limit    = (cfg_mem_size / 16 > 1) ? cfg_mem_size / 16 : 1;
        roll     = $urandom_range(0, 99);
        if (roll < 45) begin
            r.size = 16'($urandom_range(1, 8));
        end else if (roll < 70) begin
            r.size = 16'($urandom_range(1, limit));
        end else if (roll < 80 && free_sizes.size() > 0) begin
            r.size = 16'(free_sizes[$urandom_range(0, free_sizes.size() - 1)]);
        end else if (roll < 88) begin
            r.size = 16'($urandom_range(1, cfg_mem_size));
        end else if (roll < 94) begin
            r.size = 16'($urandom_range(0, 65535));
        end else if (roll < 97) begin
            r.size = '0;
        end else begin
            r.size = 16'hFFFF;
        end
        if (r.mode == MODE_FREE && used_list.size() > 0 && $urandom_range(0, 99) < 80) begin
            r.index = 5'(used_list[$urandom_range(0, used_list.size() - 1)]);
        end
        push_request(r.mode, r.policy, r.size, r.index);
    endtask

    task automatic wait_taken();
        while (requests_taken != requests_queued || pending_requests.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic wait_drained();
        wait_taken();
        while (predicted_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_register(logic [2:0] addr, logic [15:0] value);
        @(negedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= addr;
        i_pwdata  <= 32'(value);
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        if (addr == ADDR_MEM_SIZE) begin
            cfg_mem_size = value;
            rebuild_table();
        end else begin
            cfg_frag_limit = value;
        end
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    initial begin : stimulus
        logic [15:0] mem_choice [PHASES];
        logic [15:0] frag_choice [PHASES];
        int          phase;
        int          n;
        int          batch;
        int          b;
        mem_choice  = '{16'd4096, 16'd65535, 16'd1, 16'd300, 16'($urandom_range(1, 65535)), 16'd60};
        frag_choice = '{16'd5, 16'd0, 16'd65535, 16'd16, 16'($urandom_range(0, 65535)), 16'd3};
        cfg_mem_size   = RESET_MEM_SIZE;
        cfg_frag_limit = RESET_FRAG_LIMIT;
        rebuild_table();
        send_idle_pct = 33;
        recv_idle_pct = 63;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_request(MODE_ALLOC, POL_FIRST, 16'd0, 5'd0);
        push_request(MODE_ALLOC, POL_FIRST, 16'd100, 5'd31);
        push_request(MODE_ALLOC, POL_BEST, 16'd200, 5'd0);
        push_request(MODE_ALLOC, POL_WORST, 16'd300, 5'd0);
        push_request(MODE_ALLOC, 2'd3, 16'd50, 5'd0);
        push_request(MODE_FREE, POL_FIRST, 16'd0, 5'd1);
        push_request(MODE_FREE, POL_FIRST, 16'd0, 5'd1);
        push_request(MODE_FREE, POL_BEST, 16'hFFFF, 5'd31);
        push_request(MODE_ALLOC, POL_BEST, 16'd200, 5'd0);
        push_request(MODE_FREE, POL_FIRST, 16'd0, 5'd0);
        push_request(MODE_FREE, POL_FIRST, 16'd0, 5'd2);
        push_request(MODE_ALLOC, POL_FIRST, 16'd60000, 5'd0);
        push_request(MODE_ALLOC, POL_WORST, 16'hFFFF, 5'd0);
        push_request(MODE_ALLOC, POL_BEST, 16'hFFFF, 5'd0);
        push_request(MODE_FREE, POL_FIRST, 16'd0, 5'd1);
        push_request(MODE_ALLOC, POL_FIRST, 16'd3, 5'd0);
        push_request(MODE_ALLOC, POL_FIRST, 16'd3, 5'd0);
        push_request(MODE_ALLOC, POL_FIRST, 16'd3, 5'd0);
        push_request(MODE_FREE, POL_FIRST, 16'd0, 5'd0);
        push_request(MODE_FREE, POL_FIRST, 16'd0, 5'd2);
        push_request(MODE_ALLOC, POL_BEST, 16'd2, 5'd0);
        push_request(MODE_ALLOC, POL_WORST, 16'd1, 5'd0);
        push_request(MODE_ALLOC, POL_WORST, 16'd1, 5'd0);
        push_request(MODE_ALLOC, 2'd3, 16'd4096, 5'd0);

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                wait_drained();
                repeat (4) @(posedge i_clk);
                write_register(ADDR_MEM_SIZE, mem_choice[phase]);
                write_register(ADDR_FRAG_LIMIT, frag_choice[phase]);
            end
            if (phase < 2) begin
                send_idle_pct = 33;
                recv_idle_pct = 63;
            end else if (phase < 4) begin
                send_idle_pct = 63;
                recv_idle_pct = 33;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                if (n % BIAS_STRETCH == 0) begin
                    case ($urandom_range(0, 2))
                        0: begin
                            alloc_bias = 35;
                        end
                        1: begin
                            alloc_bias = 60;
                        end
                        default: begin
                            alloc_bias = 90;
                        end
                    endcase
                end
                wait_taken();
                batch = $urandom_range(1, 3);
                for (b = 0; b < batch; b++) begin
                    push_random();
                end
                n += batch;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("checked %0d results: %0d allocation and %0d release requests",
                 results_checked, alloc_count, release_count);
        $display("%0d configuration settings, %0d unsplit grants with a full table, %0d mismatches",
                 PHASES, full_table_grants, mismatch_count);
        if (mismatch_count == 0 && predicted_outcomes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_table.sv
hw/rtl/pfa_seq.sv
hw/rtl/partition_allocator_fit_policies.sv
bench/tb.sv
